// ===== src/bkpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bkpd_pkg
// shared types, constants and fixed point helpers for the balance controller
// ----------------------------------------------------------------------------
package bkpd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIVK0,
        ST_DIVK1,
        ST_POST,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        CFG_GAIN_ANGLE    = 4'd0,
        CFG_GAIN_RATE     = 4'd1,
        CFG_GAIN_POSITION = 4'd2,
        CFG_GAIN_SPEED    = 4'd3,
        CFG_TILT_CUTOFF   = 4'd4,
        CFG_POS_CLAMP     = 4'd5,
        CFG_ANGLE_NOISE   = 4'd6,
        CFG_BIAS_NOISE    = 4'd7
    } t_cfg_index;

    localparam logic [7:0] CMD_FORWARD   = 8'd1;
    localparam logic [7:0] CMD_BACK      = 8'd2;
    localparam logic [7:0] CMD_TURN_POS  = 8'd3;
    localparam logic [7:0] CMD_TURN_NEG  = 8'd4;

    localparam longint ACC_OFFSET     = 1100;
    localparam longint GYRO_OFFSET    = 30;
    localparam longint ACC_SCALE_Q32  = 18032836;
    localparam longint GYRO_SCALE_Q32 = 261888250;
    localparam longint DT_Q32         = 42949673;
    localparam longint KEEP_Q32       = 64'sd3006477107;
    localparam longint TAKE_Q32       = 64'sd1288490189;
    localparam longint SPEED_CMD      = 80;
    localparam longint TURN_CMD       = 15;
    localparam int     GAIN_BITS      = 12;
    localparam int     NOISE_BITS     = 20;

    // divider control between sequencer and divide unit
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    // round half up, then arithmetic shift right
    function automatic logic signed [63:0] rsr(input logic signed [63:0] v, input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/bkpd_div.sv =====
// ----------------------------------------------------------------------------
// bkpd_div
// signed 64 by 32 restoring divider, one quotient bit per cycle, saturated
// ----------------------------------------------------------------------------
module bkpd_div
    import bkpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_ctl           i_ctl,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output t_div_ctl           o_ctl,
    output logic signed [31:0] o_quo
);

    logic        r_busy, n_busy;
    logic        r_fin, n_fin;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_ad, n_ad;
    logic        r_neg, n_neg;
    logic signed [31:0] r_quo, n_quo;

    logic [63:0] w_an;
    logic [31:0] w_ad;
    logic [32:0] w_t;
    logic        w_ge;

    always_comb begin
        w_an = i_num[63] ? 64'(-i_num) : 64'(i_num);
        w_ad = i_den[31] ? 32'(-i_den) : 32'(i_den);
        w_t  = {r_rem, r_lo[31]};
        w_ge = w_t >= {1'b0, r_ad};

        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_ad   = r_ad;
        n_neg  = r_neg;
        n_quo  = r_quo;

        if (i_ctl.start) begin
            n_neg = i_num[63] ^ i_den[31];
            n_ad  = w_ad;
            if (w_ad == 32'd0) begin
                n_quo  = '0;
                n_done = 1'b1;
            end else if (w_an[63:32] >= w_ad) begin
                // quotient beyond 32 bits
                n_quo  = (i_num[63] ^ i_den[31]) ? 32'sh80000000 : 32'sh7fffffff;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rem  = w_an[63:32];
                n_lo   = w_an[31:0];
            end
        end else if (r_busy) begin
            n_rem = w_ge ? 32'(w_t - {1'b0, r_ad}) : w_t[31:0];
            n_lo  = {r_lo[30:0], w_ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            if (r_neg) begin
                n_quo = (r_lo > 32'h80000000) ? 32'sh80000000 : 32'(-r_lo);
            end else begin
                n_quo = r_lo[31] ? 32'sh7fffffff : r_lo;
            end
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_ad  <= n_ad;
        r_neg <= n_neg;
        r_quo <= n_quo;
    end

    always_comb begin
        o_ctl.start = r_busy;
        o_ctl.done  = r_done;
        o_quo       = r_quo;
    end

endmodule

// ===== src/balance_kalman_pd_controller.sv =====
// ----------------------------------------------------------------------------
// balance_kalman_pd_controller
// tilt kalman filter and pd drive law for a two-wheel balancing robot
// ----------------------------------------------------------------------------
// usage
//   one input request on the s_axis group is one 10 ms control tick:
//   tdata carries accel, gyro, right and left encoder counts and the command
//   code. the block answers each tick with exactly one m_axis request holding
//   left and right drive, the motors-off flag and the filtered tilt. the user
//   must write gains, cutoff, position clamp and noise terms on the cfg channel
//   (always ready) only while the block is idle; the block does not enforce it.
// datapath
//   the sequencer runs the two 32-step kalman gain divides and passes every
//   product of the tick through the single shared 33x33 multiplier one after
//   another. s_tready is high only in the idle state, so one tick is in
//   flight at a time; a new tick is taken only once the last one has reached
//   the output register.
// reset
//   synchronous active-low reset restores the register defaults, sets the
//   covariance diagonal to one and clears angle, bias, speed and position.
// stall
//   a finished result sits in the output register; a new tick is accepted
//   meanwhile and runs up to its own result, then waits for m_tready.
// ----------------------------------------------------------------------------
module balance_kalman_pd_controller
    import bkpd_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata: accel_sample[15:0], gyro_sample[31:16], right_pulses[43:32],
    //               left_pulses[55:44], command_code[63:56]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    // m_axis tdata: left_drive[15:0], right_drive[31:16], motors_off[32],
    //               tilt_estimate[48:33], zero pad[55:49]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // fixed point constants derived from the fraction width
    localparam longint DtQ    = (DT_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam longint KeepQ  = (KEEP_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam longint TakeQ  = (TAKE_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam int     NoiseUp = (FRAC_BITS > NOISE_BITS) ? FRAC_BITS - NOISE_BITS : 0;
    localparam int     NoiseDn = (FRAC_BITS < NOISE_BITS) ? NOISE_BITS - FRAC_BITS : 0;
    localparam longint NoiseHalf = (NoiseDn > 0) ? (64'sd1 <<< (NoiseDn - 1)) : 64'sd0;
    localparam longint HalfQ  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam int     DriveSh = FRAC_BITS + GAIN_BITS;
    localparam longint DriveOne = 64'sd1 <<< DriveSh;

    // configuration registers
    logic [15:0] r_gain_angle, r_gain_rate, r_gain_position, r_gain_speed;
    logic [6:0]  r_tilt_cutoff;
    logic [14:0] r_position_clamp;
    logic [15:0] r_angle_noise, r_bias_noise;

    // sequencer
    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;

    // latched tick inputs
    logic signed [SAMPLE_BITS-1:0] r_acc, r_gyr;
    logic signed [11:0] r_rp, r_lp;
    logic [7:0]         r_cmd;

    // filter and wheel state
    logic signed [31:0] r_angle, n_angle, r_bias, n_bias;
    logic signed [31:0] r_p00, n_p00, r_p01, n_p01, r_p10, n_p10, r_p11, n_p11;
    logic signed [31:0] r_speed, n_speed, r_position, n_position;

    // per-tick temporaries
    logic signed [31:0] r_acc_angle, n_acc_angle, r_rate, n_rate;
    logic signed [31:0] r_err, n_err, r_e, n_e, r_k0, n_k0, r_k1, n_k1, r_tmp, n_tmp;
    logic signed [63:0] r_sum, n_sum;

    // shared multiplier
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_full;
    logic signed [63:0] r_prod;
    logic signed [31:0] w_mq;

    // divider
    t_div_ctl           w_div_in, w_div_out;
    logic signed [63:0] w_div_num;
    logic signed [31:0] w_div_den, w_div_quo;

    // output register
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_left, n_out_left, r_out_right, n_out_right;
    logic signed [15:0] r_out_tilt, n_out_tilt;
    logic               r_out_off, n_out_off;

    // misc combinational terms
    logic signed [63:0] w_nq_angle, w_nq_bias, w_pos, w_lim, w_cut, w_turn, w_r, w_l;
    logic signed [31:0] w_d0;
    logic signed [63:0] w_speed_cmd, w_turn_cmd;
    logic               w_off;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_tilt, r_out_off, r_out_right, r_out_left};

    assign w_full = w_ma * w_mb;
    assign w_mq   = sat32(rsr(r_prod, FRAC_BITS));

    bkpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_in),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_ctl   (w_div_out),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        // noise registers from units of 2^-20 to the internal format
        w_nq_angle = ((64'(r_angle_noise) <<< NoiseUp) + NoiseHalf) >>> NoiseDn;
        w_nq_bias  = ((64'(r_bias_noise) <<< NoiseUp) + NoiseHalf) >>> NoiseDn;
        w_d0 = sat32(w_nq_angle - 64'(r_p01) - 64'(r_p10));

        case (r_cmd)
            CMD_BACK:    w_speed_cmd = -SPEED_CMD;
            CMD_FORWARD: w_speed_cmd = SPEED_CMD;
            default:     w_speed_cmd = 64'sd0;
        endcase
        case (r_cmd)
            CMD_TURN_POS: w_turn_cmd = TURN_CMD;
            CMD_TURN_NEG: w_turn_cmd = -TURN_CMD;
            default:      w_turn_cmd = 64'sd0;
        endcase

        // position integrate and clamp; saturated when stored
        w_lim = 64'(r_position_clamp) <<< FRAC_BITS;
        w_pos = 64'(r_position) + 64'(r_speed) + (w_speed_cmd <<< FRAC_BITS);
        if (w_pos < -w_lim) w_pos = -w_lim;
        if (w_pos > w_lim)  w_pos = w_lim;

        // drive law, truncated toward zero by the gain and fraction scale
        w_cut  = 64'(r_tilt_cutoff) <<< FRAC_BITS;
        w_off  = (64'(r_angle) < -w_cut) || (64'(r_angle) > w_cut);
        w_turn = w_turn_cmd <<< DriveSh;
        w_r    = r_sum + w_turn;
        w_l    = r_sum - w_turn;
        w_r    = (w_r < 0) ? ((w_r + DriveOne - 64'sd1) >>> DriveSh) : (w_r >>> DriveSh);
        w_l    = (w_l < 0) ? ((w_l + DriveOne - 64'sd1) >>> DriveSh) : (w_l >>> DriveSh);
    end

    // sequencer and datapath
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_angle = r_angle;  n_bias = r_bias;
        n_p00 = r_p00;  n_p01 = r_p01;  n_p10 = r_p10;  n_p11 = r_p11;
        n_speed = r_speed;  n_position = r_position;
        n_acc_angle = r_acc_angle;  n_rate = r_rate;  n_err = r_err;  n_e = r_e;
        n_k0 = r_k0;  n_k1 = r_k1;  n_tmp = r_tmp;  n_sum = r_sum;
        w_ma = '0;
        w_mb = '0;
        w_div_in.start = 1'b0;
        w_div_in.done  = 1'b0;
        w_div_num = 64'(r_p00) <<< FRAC_BITS;
        w_div_den = sat32(HalfQ + 64'(r_p00));
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_left = r_out_left;  n_out_right = r_out_right;
        n_out_tilt = r_out_tilt;  n_out_off = r_out_off;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CALC;
                    n_step  = '0;
                end
            end
            ST_CALC: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        w_ma = 33'(r_acc) - 33'(ACC_OFFSET);
                        w_mb = 33'(ACC_SCALE_Q32);
                    end
                    4'd1: begin
                        n_acc_angle = sat32(rsr(r_prod, 32 - FRAC_BITS));
                        w_ma = -(33'(r_gyr) + 33'(GYRO_OFFSET));
                        w_mb = 33'(GYRO_SCALE_Q32);
                    end
                    4'd2: begin
                        n_rate = sat32(rsr(r_prod, 32 - FRAC_BITS));
                        w_ma = 33'(w_d0);
                        w_mb = 33'(DtQ);
                    end
                    4'd3: begin
                        n_p00 = sat32(64'(r_p00) + 64'(w_mq));
                        w_ma = 33'(sat32(-64'(r_p11)));
                        w_mb = 33'(DtQ);
                    end
                    4'd4: begin
                        n_p01 = sat32(64'(r_p01) + 64'(w_mq));
                        n_p10 = sat32(64'(r_p10) + 64'(w_mq));
                        w_ma = 33'(sat32(64'(r_rate) - 64'(r_bias)));
                        w_mb = 33'(DtQ);
                    end
                    4'd5: begin
                        n_angle = sat32(64'(r_angle) + 64'(w_mq));
                        w_ma = 33'(sat32(w_nq_bias));
                        w_mb = 33'(DtQ);
                    end
                    default: begin
                        // last covariance update, innovation, then the first gain divide
                        n_p11 = sat32(64'(r_p11) + 64'(w_mq));
                        n_err = sat32(64'(r_acc_angle) - 64'(r_angle));
                        n_e   = w_div_den;
                        w_div_in.start = 1'b1;
                        n_state = ST_DIVK0;
                    end
                endcase
            end
            ST_DIVK0: begin
                w_div_num = 64'(r_p10) <<< FRAC_BITS;
                w_div_den = r_e;
                if (w_div_out.done) begin
                    n_k0 = w_div_quo;
                    w_div_in.start = 1'b1;
                    n_state = ST_DIVK1;
                end
            end
            ST_DIVK1: begin
                if (w_div_out.done) begin
                    n_k1 = w_div_quo;
                    n_state = ST_POST;
                    n_step  = '0;
                end
            end
            ST_POST: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        w_ma = 33'(r_k1);  w_mb = 33'(r_p00);
                    end
                    4'd1: begin
                        n_p10 = sat32(64'(r_p10) - 64'(w_mq));
                        w_ma = 33'(r_k1);  w_mb = 33'(r_p01);
                    end
                    4'd2: begin
                        n_p11 = sat32(64'(r_p11) - 64'(w_mq));
                        w_ma = 33'(r_k0);  w_mb = 33'(r_p00);
                    end
                    4'd3: begin
                        n_p00 = sat32(64'(r_p00) - 64'(w_mq));
                        w_ma = 33'(r_k0);  w_mb = 33'(r_p01);
                    end
                    4'd4: begin
                        n_p01 = sat32(64'(r_p01) - 64'(w_mq));
                        w_ma = 33'(r_k0);  w_mb = 33'(r_err);
                    end
                    4'd5: begin
                        n_angle = sat32(64'(r_angle) + 64'(w_mq));
                        w_ma = 33'(r_k1);  w_mb = 33'(r_err);
                    end
                    4'd6: begin
                        n_bias = sat32(64'(r_bias) + 64'(w_mq));
                    end
                    4'd7: begin
                        n_rate = sat32(64'(r_rate) - 64'(r_bias));
                        w_ma = 33'(r_speed);  w_mb = 33'(KeepQ);
                    end
                    4'd8: begin
                        n_tmp = w_mq;
                        // mean wheel speed is half the count sum
                        w_ma = 33'(sat32((64'(r_rp) + 64'(r_lp)) <<< (FRAC_BITS - 1)));
                        w_mb = 33'(TakeQ);
                    end
                    4'd9: begin
                        n_speed = sat32(64'(r_tmp) + 64'(w_mq));
                    end
                    4'd10: begin
                        n_position = sat32(w_pos);
                        w_ma = 33'(r_gain_angle);  w_mb = 33'(r_angle);
                    end
                    4'd11: begin
                        n_sum = r_prod;
                        w_ma = 33'(r_gain_rate);  w_mb = 33'(r_rate);
                    end
                    4'd12: begin
                        n_sum = r_sum + r_prod;
                        w_ma = 33'(r_gain_position);  w_mb = 33'(r_position);
                    end
                    4'd13: begin
                        n_sum = r_sum + r_prod;
                        w_ma = 33'(r_gain_speed);  w_mb = 33'(r_speed);
                    end
                    default: begin
                        n_sum = r_sum + r_prod;
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_off   = w_off;
                    n_out_left  = w_off ? 16'sd0 : sat16(w_l);
                    n_out_right = w_off ? 16'sd0 : sat16(w_r);
                    n_out_tilt  = sat16(rsr(64'(r_angle), FRAC_BITS - 8));
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= 32'(64'sd1 <<< FRAC_BITS);
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= 32'(64'sd1 <<< FRAC_BITS);
            r_speed     <= '0;
            r_position  <= '0;
            r_gain_angle     <= 16'd36864;
            r_gain_rate      <= 16'd10650;
            r_gain_position  <= 16'd41;
            r_gain_speed     <= 16'd8192;
            r_tilt_cutoff    <= 7'd40;
            r_position_clamp <= 15'd6000;
            r_angle_noise    <= 16'd1049;
            r_bias_noise     <= 16'd3146;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_p00       <= n_p00;
            r_p01       <= n_p01;
            r_p10       <= n_p10;
            r_p11       <= n_p11;
            r_speed     <= n_speed;
            r_position  <= n_position;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN_ANGLE:    r_gain_angle     <= i_cfg_data;
                    CFG_GAIN_RATE:     r_gain_rate      <= i_cfg_data;
                    CFG_GAIN_POSITION: r_gain_position  <= i_cfg_data;
                    CFG_GAIN_SPEED:    r_gain_speed     <= i_cfg_data;
                    CFG_TILT_CUTOFF:   r_tilt_cutoff    <= i_cfg_data[6:0];
                    CFG_POS_CLAMP:     r_position_clamp <= i_cfg_data[14:0];
                    CFG_ANGLE_NOISE:   r_angle_noise    <= i_cfg_data;
                    CFG_BIAS_NOISE:    r_bias_noise     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_acc <= i_s_tdata[SAMPLE_BITS-1:0];
            r_gyr <= i_s_tdata[16+SAMPLE_BITS-1:16];
            r_rp  <= i_s_tdata[43:32];
            r_lp  <= i_s_tdata[55:44];
            r_cmd <= i_s_tdata[63:56];
        end
        r_prod      <= w_full[63:0];
        r_acc_angle <= n_acc_angle;
        r_rate      <= n_rate;
        r_err       <= n_err;
        r_e         <= n_e;
        r_k0        <= n_k0;
        r_k1        <= n_k1;
        r_tmp       <= n_tmp;
        r_sum       <= n_sum;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_tilt  <= n_out_tilt;
        r_out_off   <= n_out_off;
    end

    // an accepted tick always starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_CALC))
        else $error("accepted tick did not start the sequencer");

    // stopped motors carry zero drive
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_off) |-> (r_out_left == 16'sd0 && r_out_right == 16'sd0))
        else $error("drive not zero with motors off");

    // divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_out.done |-> (r_state == ST_DIVK0 || r_state == ST_DIVK1))
        else $error("divider result outside a divide wait");

endmodule

// ===== dv/balance_kalman_pd_controller_tb.sv =====
// ----------------------------------------------------------------------------
// balance_kalman_pd_controller_tb
// self-checking testbench for the tilt kalman filter and pd drive controller:
// drives control ticks on the input stream, predicts every drive result with
// an in-bench fixed point model of the filter and drive law, and checks each
// output request field by field under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module balance_kalman_pd_controller_tb;
    import bkpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC        = 16;
    localparam int  LIMIT_CYCLE = 600000;
    localparam int  DRAIN_WAIT  = 150;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               off;
        logic signed [15:0] tilt;
    } t_drive;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    balance_kalman_pd_controller DUT (.*);

    always #6 i_clk = ~i_clk;

    // model copy of the registers
    longint cfg_ga, cfg_gr, cfg_gp, cfg_gs, cfg_cut, cfg_clamp, cfg_qa, cfg_qb;
    // model copy of the filter and wheel state
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb, whl_speed, whl_pos;

    t_drive drive_queue[$];
    int     errors = 0;
    int     cycles = 0;
    int     hold_req = 0;    // long sink hold-off, counted by the stall process
    int     stall_mode = 0;

    // ------------------------------------------------------------------
    // fixed point helpers
    // ------------------------------------------------------------------
    function automatic longint rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip(rnd(clip(a, 32) * clip(b, 32), FRAC), 32);
    endfunction

    // one control tick through the filter and drive law
    function automatic t_drive tick_predict(logic [63:0] d);
        longint acc, gyr, rp, lp, dt, acc_ang, rate, d0, d1, err, e, k0, k1;
        longint p00, p01, scmd, tcmd, mean, lim, cut, sum, one;
        logic [7:0] cmd;
        t_drive res;
        acc = longint'($signed(d[15:0]));
        gyr = longint'($signed(d[31:16]));
        rp  = longint'($signed(d[43:32]));
        lp  = longint'($signed(d[55:44]));
        cmd = d[63:56];
        dt  = rnd(DT_Q32, 32 - FRAC);

        acc_ang = clip(rnd((acc - ACC_OFFSET) * ACC_SCALE_Q32, 32 - FRAC), 32);
        rate    = clip(rnd(-(gyr + GYRO_OFFSET) * GYRO_SCALE_Q32, 32 - FRAC), 32);

        // predict
        est_angle = clip(est_angle + qmul(clip(rate - est_bias, 32), dt), 32);
        d0   = clip(rnd(cfg_qa, NOISE_BITS - FRAC) - p_ab - p_ba, 32);
        d1   = -p_bb;
        p_aa = clip(p_aa + qmul(d0, dt), 32);
        p_ab = clip(p_ab + qmul(d1, dt), 32);
        p_ba = clip(p_ba + qmul(d1, dt), 32);
        p_bb = clip(p_bb + qmul(rnd(cfg_qb, NOISE_BITS - FRAC), dt), 32);

        // measurement update, gains are zero when innovation variance is zero
        err = clip(acc_ang - est_angle, 32);
        e   = clip((64'sd1 <<< (FRAC - 1)) + p_aa, 32);
        if (e == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = clip((p_aa * (64'sd1 <<< FRAC)) / e, 32);
            k1 = clip((p_ba * (64'sd1 <<< FRAC)) / e, 32);
        end
        p00  = p_aa;
        p01  = p_ab;
        p_aa = clip(p_aa - qmul(k0, p00), 32);
        p_ab = clip(p_ab - qmul(k0, p01), 32);
        p_ba = clip(p_ba - qmul(k1, p00), 32);
        p_bb = clip(p_bb - qmul(k1, p01), 32);
        est_angle = clip(est_angle + qmul(k0, err), 32);
        est_bias  = clip(est_bias + qmul(k1, err), 32);
        rate      = clip(rate - est_bias, 32);

        // unknown codes leave both commands at zero
        scmd = 0;
        tcmd = 0;
        if (cmd == CMD_BACK) scmd = -SPEED_CMD;
        else if (cmd == CMD_FORWARD) scmd = SPEED_CMD;
        if (cmd == CMD_TURN_POS) tcmd = TURN_CMD;
        else if (cmd == CMD_TURN_NEG) tcmd = -TURN_CMD;

        // wheel speed low-pass and clamped position
        mean      = clip((rp + lp) * (64'sd1 <<< (FRAC - 1)), 32);
        whl_speed = clip(qmul(whl_speed, rnd(KEEP_Q32, 32 - FRAC))
                         + qmul(mean, rnd(TAKE_Q32, 32 - FRAC)), 32);
        whl_pos   = whl_pos + whl_speed + scmd * (64'sd1 <<< FRAC);
        lim       = cfg_clamp * (64'sd1 <<< FRAC);
        if (whl_pos < -lim) whl_pos = -lim;
        if (whl_pos > lim) whl_pos = lim;
        whl_pos   = clip(whl_pos, 32);

        // drive, zero beyond the tilt cutoff
        cut     = cfg_cut * (64'sd1 <<< FRAC);
        res.off = (est_angle < -cut) || (est_angle > cut);
        if (res.off) begin
            res.left  = '0;
            res.right = '0;
        end else begin
            one = 64'sd1 <<< (FRAC + GAIN_BITS);
            sum = cfg_ga * est_angle + cfg_gr * rate + cfg_gp * whl_pos + cfg_gs * whl_speed;
            res.right = 16'(clip((sum + tcmd * one) / one, 16));
            res.left  = 16'(clip((sum - tcmd * one) / one, 16));
        end
        res.tilt = 16'(clip(rnd(est_angle, FRAC - 8), 16));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLE) begin
            $display("balance_kalman_pd_controller test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each output request against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_drive want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_queue.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = drive_queue.pop_front();
                if (o_m_tdata[15:0] !== want.left) begin
                    $display("%0t left_drive exp %0d act %0d", $time, want.left,
                             $signed(o_m_tdata[15:0]));
                    errors++;
                end
                if (o_m_tdata[31:16] !== want.right) begin
                    $display("%0t right_drive exp %0d act %0d", $time, want.right,
                             $signed(o_m_tdata[31:16]));
                    errors++;
                end
                if (o_m_tdata[32] !== want.off) begin
                    $display("%0t motors_off exp %0b act %0b", $time, want.off,
                             o_m_tdata[32]);
                    errors++;
                end
                if (o_m_tdata[48:33] !== want.tilt) begin
                    $display("%0t tilt_estimate exp %0d act %0d", $time, want.tilt,
                             $signed(o_m_tdata[48:33]));
                    errors++;
                end
                if (o_m_tdata[55:49] !== '0) begin
                    $display("%0t pad exp 0 act %h", $time, o_m_tdata[55:49]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink stall process: mode picked by the tests, long hold on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            hold_left = 0;
            i_m_tready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 1) == 1);
                2: i_m_tready <= ((cycles % 37) < 5);
                default: i_m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------
    // offer one tick; tvalid stays high afterwards for back-to-back requests
    task automatic send_tick(logic [63:0] d);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        drive_queue.push_back(tick_predict(d));
    endtask

    task automatic source_gap(int n);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= {$urandom, $urandom};
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        source_gap(0);
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write; indexes past the last register must be ignored
    task automatic cfg_write(logic [3:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_ANGLE:    cfg_ga    = val;
            CFG_GAIN_RATE:     cfg_gr    = val;
            CFG_GAIN_POSITION: cfg_gp    = val;
            CFG_GAIN_SPEED:    cfg_gs    = val;
            CFG_TILT_CUTOFF:   cfg_cut   = val[6:0];
            CFG_POS_CLAMP:     cfg_clamp = val[14:0];
            CFG_ANGLE_NOISE:   cfg_qa    = val;
            CFG_BIAS_NOISE:    cfg_qb    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pack_tick(logic [15:0] acc, logic [15:0] gyr,
                                              logic [11:0] rp, logic [11:0] lp,
                                              logic [7:0] cmd);
        return {cmd, lp, rp, gyr, acc};
    endfunction

    // mostly near-upright ticks with real commands, some raw noise
    function automatic logic [63:0] rand_tick();
        logic [7:0] cmd;
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        cmd = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        return pack_tick(16'(1100 + $urandom_range(0, 6000) - 3000),
                         16'(-30 + $urandom_range(0, 2000) - 1000),
                         12'($urandom_range(0, 120) - 60),
                         12'($urandom_range(0, 120) - 60), cmd);
    endfunction

    task automatic random_burst(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 1) source_gap($urandom_range(1, 120));
            end
            burst--;
            send_tick(rand_tick());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        stall_mode = 0;
        send_tick(pack_tick(16'h8000, 16'h8000, 12'h800, 12'h800, CMD_FORWARD));
        send_tick(pack_tick(16'h7fff, 16'h7fff, 12'h7ff, 12'h7ff, CMD_BACK));
        send_tick(pack_tick(16'h0000, 16'h0000, 12'h000, 12'h000, 8'hff));
        send_tick(pack_tick(16'hffff, 16'hffff, 12'hfff, 12'hfff, 8'h00));
        // back to upright: tilt returns inside the cutoff
        for (int i = 0; i < 6; i++)
            send_tick(pack_tick(16'd1100, -16'sd30, 12'd3, -12'sd3, 8'd0));
        wait_drained();
    endtask

    task automatic test_commands();
        logic [7:0] codes[6] = '{8'd0, CMD_FORWARD, CMD_BACK, CMD_TURN_POS,
                                 CMD_TURN_NEG, 8'd200};
        stall_mode = 1;
        foreach (codes[i]) begin
            send_tick(pack_tick(16'd1300, 16'd100, 12'd20, 12'd10, codes[i]));
            send_tick(pack_tick(16'd900, -16'sd200, -12'sd15, 12'd5, codes[i]));
        end
        wait_drained();
    endtask

    // tilt at, above and below a zero cutoff, then random ticks with a cutoff of two
    task automatic test_tilt_cutoff();
        cfg_write(CFG_TILT_CUTOFF, 16'd0);
        send_tick(pack_tick(16'd1100, -16'sd30, 12'd0, 12'd0, 8'd0));
        send_tick(pack_tick(16'd1400, -16'sd30, 12'd0, 12'd0, 8'd0));
        send_tick(pack_tick(16'd700, -16'sd30, 12'd0, 12'd0, 8'd0));
        wait_drained();
        cfg_write(CFG_TILT_CUTOFF, 16'd2);
        random_burst(5);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        logic [15:0] vals[3];
        for (int s = 0; s < 4; s++) begin
            stall_mode = s;
            for (int r = 0; r < 8; r++) begin
                vals = '{16'h0000, 16'hffff, 16'($urandom)};
                cfg_write(4'(r), vals[(s + r) % 3]);
            end
            // cutoff kept usable in most settings
            if (s != 1) cfg_write(CFG_TILT_CUTOFF, 16'(s == 3 ? 90 : $urandom_range(5, 90)));
            cfg_write(4'(8 + $urandom_range(0, 7)), 16'($urandom));
            random_burst(60);
            wait_drained();
        end
        cfg_write(CFG_GAIN_ANGLE, 16'd36864);
        cfg_write(CFG_GAIN_RATE, 16'd10650);
        cfg_write(CFG_GAIN_POSITION, 16'd41);
        cfg_write(CFG_GAIN_SPEED, 16'd8192);
        cfg_write(CFG_TILT_CUTOFF, 16'd40);
        cfg_write(CFG_POS_CLAMP, 16'd6000);
        cfg_write(CFG_ANGLE_NOISE, 16'd1049);
        cfg_write(CFG_BIAS_NOISE, 16'd3146);
    endtask

    task automatic test_random_traffic();
        for (int s = 0; s < 4; s++) begin
            stall_mode = s;
            random_burst(70);
        end
        wait_drained();
    endtask

    // sink holds off long while the source keeps offering, then a full pause
    task automatic test_backpressure();
        stall_mode = 0;
        hold_req = 500;
        for (int i = 0; i < 6; i++) send_tick(rand_tick());
        wait_drained();
        random_burst(10);
        wait_drained();
        stall_mode = 1;
        random_burst(10);
        wait_drained();
    endtask

    initial begin
        cfg_ga = 36864; cfg_gr = 10650; cfg_gp = 41; cfg_gs = 8192;
        cfg_cut = 40; cfg_clamp = 6000; cfg_qa = 1049; cfg_qb = 3146;
        est_angle = 0; est_bias = 0;
        p_aa = 64'sd1 <<< FRAC; p_ab = 0; p_ba = 0; p_bb = 64'sd1 <<< FRAC;
        whl_speed = 0; whl_pos = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_field_extremes();
        test_commands();
        test_tilt_cutoff();
        test_backpressure();
        test_config_sweep();
        test_random_traffic();

        wait_drained();
        if (errors == 0) begin
            $display("balance_kalman_pd_controller test passed");
        end else begin
            $display("balance_kalman_pd_controller test failed");
        end
        $finish;
    end

endmodule
